// ===== src/ctb_pkg.sv =====
// shared constants, types and command/status structs for the cartesian tree builder
package ctb_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int LBL_W     = 7;
  localparam int DATA_W    = 32;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_IK,
    ST_SORT_J,
    ST_SORT_W,
    ST_CLEAR,
    ST_B0,
    ST_B0P,
    ST_BK,
    ST_BKP,
    ST_WALK,
    ST_UP,
    ST_RIGHT,
    ST_RIGHT2,
    ST_LEFT,
    ST_NEXT,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

  typedef struct packed {
    state_t op;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic j_end;
    logic i_end;
    logic k_end;
    logic single;
    logic walk_up;
    logic attach_right;
    logic r_nonzero;
    logic out_taken;
  } status_t;

endpackage

// ===== src/ctb_ctrl.sv =====
// sequencer for load, rank sort, rightmost-path build and result emission
module ctb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  ctb_pkg::status_t status,
  output ctb_pkg::cmd_t    cmd
);

  ctb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctb_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = state;
    case (state)
      ctb_pkg::ST_LOAD:    if (status.in_last) state_next = ctb_pkg::ST_SORT_I;
      ctb_pkg::ST_SORT_I:  state_next = ctb_pkg::ST_SORT_IK;
      ctb_pkg::ST_SORT_IK: state_next = ctb_pkg::ST_SORT_J;
      ctb_pkg::ST_SORT_J:  if (status.j_end) state_next = ctb_pkg::ST_SORT_W;
      ctb_pkg::ST_SORT_W:  state_next = status.i_end ? ctb_pkg::ST_CLEAR : ctb_pkg::ST_SORT_I;
      ctb_pkg::ST_CLEAR:   if (status.j_end) state_next = ctb_pkg::ST_B0;
      ctb_pkg::ST_B0:      state_next = ctb_pkg::ST_B0P;
      ctb_pkg::ST_B0P:     state_next = status.single ? ctb_pkg::ST_EM_RD : ctb_pkg::ST_BK;
      ctb_pkg::ST_BK:      state_next = ctb_pkg::ST_BKP;
      ctb_pkg::ST_BKP:     state_next = ctb_pkg::ST_WALK;
      ctb_pkg::ST_WALK: begin
        if (status.walk_up) state_next = ctb_pkg::ST_UP;
        else if (status.attach_right) state_next = ctb_pkg::ST_RIGHT;
        else state_next = ctb_pkg::ST_LEFT;
      end
      ctb_pkg::ST_UP:      state_next = ctb_pkg::ST_WALK;
      ctb_pkg::ST_RIGHT:   state_next = status.r_nonzero ? ctb_pkg::ST_RIGHT2 : ctb_pkg::ST_NEXT;
      ctb_pkg::ST_RIGHT2:  state_next = ctb_pkg::ST_NEXT;
      ctb_pkg::ST_LEFT:    state_next = ctb_pkg::ST_NEXT;
      ctb_pkg::ST_NEXT:    state_next = status.k_end ? ctb_pkg::ST_EM_RD : ctb_pkg::ST_BK;
      ctb_pkg::ST_EM_RD:   state_next = ctb_pkg::ST_EM_LD;
      ctb_pkg::ST_EM_LD:   state_next = ctb_pkg::ST_EM_WAIT;
      ctb_pkg::ST_EM_WAIT: begin
        if (status.out_taken) begin
          state_next = status.k_end ? ctb_pkg::ST_LOAD : ctb_pkg::ST_EM_RD;
        end
      end
      default:             state_next = ctb_pkg::ST_LOAD;
    endcase
  end

endmodule

// ===== src/ctb_datapath.sv =====
// point stores, sort rank counter, tree link memories and output register
module ctb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ctb_pkg::cmd_t                       cmd,
  output ctb_pkg::status_t                    status,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ctb_pkg::DATA_W-1:0]   key,
  input  logic signed [ctb_pkg::DATA_W-1:0]   priority_req,
  input  logic                                last_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ctb_pkg::LBL_W-1:0]           node_label,
  output logic [ctb_pkg::LBL_W-1:0]           parent_label,
  output logic [ctb_pkg::LBL_W-1:0]           left_label,
  output logic [ctb_pkg::LBL_W-1:0]           right_label,
  output logic                                capacity_exceeded,
  output logic                                last_result
);

  localparam int IW = ctb_pkg::IDX_W;
  localparam int LW = ctb_pkg::LBL_W;
  localparam int DW = ctb_pkg::DATA_W;
  localparam int N  = ctb_pkg::MAX_NODES;

  logic signed [DW-1:0] key_mem  [N];
  logic signed [DW-1:0] prio_mem [N];
  logic [IW-1:0]        sort_mem [N];
  logic [LW-1:0]        par_mem  [N];
  logic [LW-1:0]        lft_mem  [N];
  logic [LW-1:0]        rgt_mem  [N];

  logic signed [DW-1:0] key_rd, prio_rd, ki, pc, plast;
  logic [IW-1:0]        sort_rd;
  logic [LW-1:0]        par_rd, lft_rd, rgt_rd;
  logic [IW-1:0]        key_ra, prio_ra, sort_ra, par_ra, rgt_ra;

  logic [LW-1:0] count;
  logic          overflow;
  logic [IW-1:0] i, j, k, rank, last, c, rr_idx;
  logic [LW-1:0] parlast;
  logic [LW-1:0] parlast_m1, rgt_m1;

  logic          par_we, lft_we, rgt_we;
  logic [IW-1:0] par_wa, lft_wa, rgt_wa;
  logic [LW-1:0] par_wd, lft_wd, rgt_wd;

  logic in_fire, key_less, pc_less;

  assign in_stall = (cmd.op != ctb_pkg::ST_LOAD);
  assign in_fire  = in_valid && !in_stall;

  assign parlast_m1 = parlast - LW'(1);
  assign rgt_m1     = rgt_rd - LW'(1);
  assign pc_less    = (pc < plast);
  assign key_less   = (key_rd < ki) || ((key_rd == ki) && (j < i));

  assign status.in_last      = in_fire && last_item;
  assign status.j_end        = (LW'(j) + LW'(1) == count);
  assign status.i_end        = (LW'(i) + LW'(1) == count);
  assign status.k_end        = (LW'(k) + LW'(1) == count);
  assign status.single       = (count == LW'(1));
  assign status.walk_up      = (parlast != '0) && pc_less;
  assign status.attach_right = !pc_less;
  assign status.r_nonzero    = (rgt_rd != '0);
  assign status.out_taken    = out_valid && !out_stall;

  // read addresses
  always_comb begin
    key_ra  = j;
    prio_ra = sort_rd;
    sort_ra = '0;
    par_ra  = k;
    rgt_ra  = k;
    case (cmd.op)
      ctb_pkg::ST_SORT_I:  key_ra = i;
      ctb_pkg::ST_SORT_IK: key_ra = '0;
      ctb_pkg::ST_SORT_J:  key_ra = j + IW'(1);
      ctb_pkg::ST_WALK: begin
        prio_ra = parlast_m1[IW-1:0];
        par_ra  = parlast_m1[IW-1:0];
        rgt_ra  = last;
      end
      ctb_pkg::ST_B0P:     sort_ra = IW'(1);
      ctb_pkg::ST_NEXT:    sort_ra = k + IW'(1);
      default: begin
      end
    endcase
  end

  // link writes
  always_comb begin
    par_we = 1'b0; par_wa = j; par_wd = '0;
    lft_we = 1'b0; lft_wa = j; lft_wd = '0;
    rgt_we = 1'b0; rgt_wa = j; rgt_wd = '0;
    case (cmd.op)
      ctb_pkg::ST_CLEAR: begin
        par_we = 1'b1; lft_we = 1'b1; rgt_we = 1'b1;
      end
      ctb_pkg::ST_RIGHT: begin
        lft_we = 1'b1; lft_wa = c;    lft_wd = rgt_rd;
        par_we = 1'b1; par_wa = c;    par_wd = LW'(last) + LW'(1);
        rgt_we = 1'b1; rgt_wa = last; rgt_wd = LW'(c) + LW'(1);
      end
      ctb_pkg::ST_RIGHT2: begin
        par_we = 1'b1; par_wa = rr_idx; par_wd = LW'(c) + LW'(1);
      end
      ctb_pkg::ST_LEFT: begin
        lft_we = 1'b1; lft_wa = c;    lft_wd = LW'(last) + LW'(1);
        par_we = 1'b1; par_wa = last; par_wd = LW'(c) + LW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[key_ra];
    prio_rd <= prio_mem[prio_ra];
    sort_rd <= sort_mem[sort_ra];
    par_rd  <= par_mem[par_ra];
    lft_rd  <= lft_mem[k];
    rgt_rd  <= rgt_mem[rgt_ra];
    if (in_fire && count < LW'(N)) begin
      key_mem[count[IW-1:0]]  <= key;
      prio_mem[count[IW-1:0]] <= priority_req;
    end
    if (cmd.op == ctb_pkg::ST_SORT_W) sort_mem[rank] <= i;
    if (par_we) par_mem[par_wa] <= par_wd;
    if (lft_we) lft_mem[lft_wa] <= lft_wd;
    if (rgt_we) rgt_mem[rgt_wa] <= rgt_wd;
  end

  // counters and build registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ctb_pkg::ST_LOAD:    i <= '0;
      ctb_pkg::ST_SORT_I:  rank <= '0;
      ctb_pkg::ST_SORT_IK: begin
        ki <= key_rd;
        j  <= '0;
      end
      ctb_pkg::ST_SORT_J: begin
        rank <= rank + IW'(key_less);
        j    <= j + IW'(1);
      end
      ctb_pkg::ST_SORT_W: begin
        i <= i + IW'(1);
        j <= '0;
      end
      ctb_pkg::ST_CLEAR:   j <= j + IW'(1);
      ctb_pkg::ST_B0:      last <= sort_rd;
      ctb_pkg::ST_B0P: begin
        plast   <= prio_rd;
        parlast <= '0;
        k       <= status.single ? '0 : IW'(1);
      end
      ctb_pkg::ST_BK:      c <= sort_rd;
      ctb_pkg::ST_BKP:     pc <= prio_rd;
      ctb_pkg::ST_WALK:    if (status.walk_up) last <= parlast_m1[IW-1:0];
      ctb_pkg::ST_UP: begin
        plast   <= prio_rd;
        parlast <= par_rd;
      end
      ctb_pkg::ST_RIGHT: begin
        rr_idx  <= rgt_m1[IW-1:0];
        parlast <= LW'(last) + LW'(1);
      end
      ctb_pkg::ST_LEFT:    parlast <= '0;
      ctb_pkg::ST_NEXT: begin
        last  <= c;
        plast <= pc;
        k     <= status.k_end ? '0 : k + IW'(1);
      end
      ctb_pkg::ST_EM_LD: begin
        node_label        <= LW'(k) + LW'(1);
        parent_label      <= par_rd;
        left_label        <= lft_rd;
        right_label       <= rgt_rd;
        capacity_exceeded <= overflow;
        last_result       <= status.k_end;
      end
      ctb_pkg::ST_EM_WAIT: if (status.out_taken && !status.k_end) k <= k + IW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (count < LW'(N)) count <= count + LW'(1);
        else overflow <= 1'b1;
      end
      if (cmd.op == ctb_pkg::ST_EM_LD) out_valid <= 1'b1;
      if (cmd.op == ctb_pkg::ST_EM_WAIT && status.out_taken) begin
        out_valid <= 1'b0;
        if (status.k_end) begin
          count    <= '0;
          overflow <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/cartesian_tree_build.sv =====
// top level of the cartesian tree builder
//
//  channel  direction  handshake           payload
//  in       in         in_valid/in_stall   key, priority_req, last_item
//  out      out        out_valid/out_stall node/parent/left/right labels, flags
//
// loading accepts one point per cycle; after the last point the rank sort makes
// one key memory read per compared pair, then the links are cleared, the
// rightmost-path build inserts each node after any steps up the path,
// and emission presents each result and holds it through any output stall
// reset returns to the empty load state; in_stall is high from the last point
// until the final result transfer
module cartesian_tree_build (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ctb_pkg::DATA_W-1:0] key,
  input  logic signed [ctb_pkg::DATA_W-1:0] priority_req,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ctb_pkg::LBL_W-1:0]         node_label,
  output logic [ctb_pkg::LBL_W-1:0]         parent_label,
  output logic [ctb_pkg::LBL_W-1:0]         left_label,
  output logic [ctb_pkg::LBL_W-1:0]         right_label,
  output logic                              capacity_exceeded,
  output logic                              last_result
);

  ctb_pkg::cmd_t    cmd;
  ctb_pkg::status_t status;

  ctb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ctb_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .key               (key),
    .priority_req      (priority_req),
    .last_item         (last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .node_label        (node_label),
    .parent_label      (parent_label),
    .left_label        (left_label),
    .right_label       (right_label),
    .capacity_exceeded (capacity_exceeded),
    .last_result       (last_result)
  );

endmodule
